FILE: src/ccrs_pkg.sv
package ccrs_pkg;

  localparam int unsigned YearW   = 16;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DateW   = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned MilliW  = 10;
  localparam int unsigned RawW    = 8;

  localparam logic [YearW-1:0]   YearUnset   = 16'd1970;
  localparam logic [RawW-1:0]    RawMonthMax = 8'd12;
  localparam logic [RawW-1:0]    RawDateMax  = 8'd31;
  localparam logic [RawW-1:0]    RawHourMax  = 8'd23;
  localparam logic [RawW-1:0]    RawSixtyMax = 8'd59;
  localparam logic [MilliW-1:0]  MilliLast   = 10'd999;
  localparam logic [SecondW-1:0] SecondLast  = 6'd59;
  localparam logic [MinuteW-1:0] MinuteLast  = 6'd59;
  localparam logic [HourW-1:0]   HourLast    = 5'd23;
  localparam logic [MonthW-1:0]  MonthLast   = 4'd12;

  // Divisibility by 25 on a 16-bit year: multiply by the inverse of 25
  // modulo 2^16; multiples of 25 map onto 0 .. floor((2^16-1)/25).
  localparam logic [YearW-1:0] Inv25   = 16'd23593;
  localparam logic [YearW-1:0] Div25Max = 16'd2621;

  typedef enum logic [0:0] {
    REQ_TICK = 1'b0,
    REQ_SYNC = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic [0:0]      req_type;
    logic [YearW-1:0] rtc_year;
    logic [RawW-1:0]  rtc_month;
    logic [RawW-1:0]  rtc_date;
    logic [RawW-1:0]  rtc_hour;
    logic [RawW-1:0]  rtc_minute;
    logic [RawW-1:0]  rtc_second;
  } req_t;

  typedef struct packed {
    logic [YearW-1:0]   cur_year;
    logic [MonthW-1:0]  cur_month;
    logic [DateW-1:0]   cur_date;
    logic [HourW-1:0]   cur_hour;
    logic [MinuteW-1:0] cur_minute;
    logic [SecondW-1:0] cur_second;
    logic [MilliW-1:0]  cur_millisecond;
    logic               sync_taken;
  } rsp_t;

  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DateW-1:0]   date;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [MilliW-1:0]  milli;
  } time_t;

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * Inv25;
    div25 = (prod <= Div25Max);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  // Month zero (only seen after reset) counts as a 30-day month.
  function automatic logic [DateW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DateW-1:0] len;
    case (m)
      4'd2:                                      len = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                   len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

FILE: src/ccrs_if.sv
interface ccrs_req_if;
  logic            valid;
  logic            ready;
  ccrs_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ccrs_rsp_if;
  logic            valid;
  logic            ready;
  ccrs_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/calendar_clock_with_rtc_sync.sv
// Calendar clock: Gregorian date and time to the millisecond, with RTC sync.
// Channels: req (sink) takes one request per handshake, either a one
// millisecond tick or a sync carrying a raw RTC reading; rsp (source) returns
// one result per request with the full time after it and a flag telling
// whether the RTC reading was taken.
// Path: an accepted request waits in the input register, and its result is
// registered in the result register, which drives rsp.valid.
// Throughput: one request per cycle unless rsp stalls. The input register
// feeds the carry logic (ms -> s -> min -> h -> day -> month -> year, leap
// by the 4/100/400 rule) and the result register in a single pass; the time
// registers update in the same cycle, so back-to-back requests each see the
// time left by the last. Stall: while rsp is held off, the result register
// holds its value, one more request waits in the input register, and req.ready
// then drops. Reset (rst, synchronous, active high): the time clears to all
// zero (month and date 0), and both pipeline registers are emptied.
module calendar_clock_with_rtc_sync (
  input  logic              clk,
  input  logic              rst,
  ccrs_req_if.sink          req,
  ccrs_rsp_if.source        rsp
);

  logic             in_vld;
  ccrs_pkg::req_t   in_item;
  logic             out_vld;
  ccrs_pkg::rsp_t   out_item;
  ccrs_pkg::time_t  now;
  ccrs_pkg::time_t  now_next;
  ccrs_pkg::rsp_t   result;
  logic             step_go;

  // Move the held request on whenever the result register is free or draining.
  assign step_go   = in_vld && (!out_vld || rsp.ready);
  assign req.ready = !in_vld || step_go;

  ccrs_step u_step (
    .state      (now),
    .item       (in_item),
    .state_next (now_next),
    .result     (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item <= req.data;
    end
  end

  // Time registers: advance once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      now <= '0;
    end else if (step_go) begin
      now <= now_next;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (step_go) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_item <= result;
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.data  = out_item;

endmodule

FILE: src/ccrs_step.sv
module ccrs_step (
  input  ccrs_pkg::time_t state,
  input  ccrs_pkg::req_t  item,
  output ccrs_pkg::time_t state_next,
  output ccrs_pkg::rsp_t  result
);

  logic                            is_sync;
  logic                            ok;
  logic                            taken;
  logic                            adv;
  ccrs_pkg::time_t                 base;
  logic                            leap;
  logic [ccrs_pkg::DateW-1:0]      len;
  logic [ccrs_pkg::DateW:0]        date_inc;
  logic                            sec_wrap;
  logic                            min_wrap;
  logic                            hour_wrap;
  logic                            day_over;
  logic                            mon_wrap;
  ccrs_pkg::time_t                 nxt;

  assign is_sync = (item.req_type == ccrs_pkg::REQ_SYNC);

  // Validate the RTC reading.
  assign ok = (item.rtc_year != ccrs_pkg::YearUnset)
           && (item.rtc_month != 8'd0) && (item.rtc_month <= ccrs_pkg::RawMonthMax)
           && (item.rtc_date != 8'd0) && (item.rtc_date <= ccrs_pkg::RawDateMax)
           && (item.rtc_hour <= ccrs_pkg::RawHourMax)
           && (item.rtc_minute <= ccrs_pkg::RawSixtyMax)
           && (item.rtc_second <= ccrs_pkg::RawSixtyMax);

  assign taken = is_sync && ok;

  // Load year through minute from a valid reading; seconds stay as held.
  always_comb begin
    base = state;
    if (taken) begin
      base.year   = item.rtc_year;
      base.month  = item.rtc_month[ccrs_pkg::MonthW-1:0];
      base.date   = item.rtc_date[ccrs_pkg::DateW-1:0];
      base.hour   = item.rtc_hour[ccrs_pkg::HourW-1:0];
      base.minute = item.rtc_minute[ccrs_pkg::MinuteW-1:0];
    end
  end

  always_comb begin
    if (!is_sync) begin
      adv = (state.milli >= ccrs_pkg::MilliLast);
    end else if (ok) begin
      adv = (state.second == item.rtc_second[ccrs_pkg::SecondW-1:0]);
    end else begin
      adv = 1'b1;
    end
  end

  assign leap      = ccrs_pkg::is_leap(base.year);
  assign len       = ccrs_pkg::month_len(base.month, leap);
  assign date_inc  = {1'b0, base.date} + 6'd1;
  assign sec_wrap  = (base.second >= ccrs_pkg::SecondLast);
  assign min_wrap  = (base.minute >= ccrs_pkg::MinuteLast);
  assign hour_wrap = (base.hour >= ccrs_pkg::HourLast);
  assign day_over  = (date_inc > {1'b0, len});
  assign mon_wrap  = (base.month >= ccrs_pkg::MonthLast);

  // Ripple the one-second carry, or load a taken RTC second; then update the ms.
  always_comb begin
    nxt = base;
    if (adv) begin
      if (!sec_wrap) begin
        nxt.second = base.second + 6'd1;
      end else begin
        nxt.second = '0;
        if (!min_wrap) begin
          nxt.minute = base.minute + 6'd1;
        end else begin
          nxt.minute = '0;
          if (!hour_wrap) begin
            nxt.hour = base.hour + 5'd1;
          end else begin
            nxt.hour = '0;
            if (!day_over) begin
              nxt.date = date_inc[ccrs_pkg::DateW-1:0];
            end else begin
              nxt.date = 5'd1;
              if (!mon_wrap) begin
                nxt.month = base.month + 4'd1;
              end else begin
                nxt.month = 4'd1;
                nxt.year  = base.year + 16'd1;
              end
            end
          end
        end
      end
    end else if (taken) begin
      nxt.second = item.rtc_second[ccrs_pkg::SecondW-1:0];
    end
    if (is_sync || adv) begin
      nxt.milli = '0;
    end else begin
      nxt.milli = state.milli + 10'd1;
    end
  end

  assign state_next = nxt;

  assign result.cur_year        = nxt.year;
  assign result.cur_month       = nxt.month;
  assign result.cur_date        = nxt.date;
  assign result.cur_hour        = nxt.hour;
  assign result.cur_minute      = nxt.minute;
  assign result.cur_second      = nxt.second;
  assign result.cur_millisecond = nxt.milli;
  assign result.sync_taken      = taken;

endmodule
